// ===== design/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude core.
`default_nettype none

package sem_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 16;
  localparam int COL_OUT_W = 11;
  localparam int FW_W = 12;
  localparam int FH_W = 16;
  localparam int CFG_W = 16;
  localparam int SLOTS = 4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

  localparam logic [15:0] LUMA_WEIGHT_RED = 16'd19595;
  localparam logic [15:0] LUMA_WEIGHT_GREEN = 16'd38470;
  localparam logic [15:0] LUMA_WEIGHT_BLUE = 16'd7471;

  localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    SLOT_UP_LEFT = 2'd0,
    SLOT_UP = 2'd1,
    SLOT_LEFT = 2'd2,
    SLOT_HERE = 2'd3
  } slot_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic [PIX_W-1:0] edge_value;
    logic [ROW_W-1:0] row_prev;
    logic [ROW_W-1:0] row_cur;
    logic [COL_OUT_W-1:0] col_prev;
    logic [COL_OUT_W-1:0] col_cur;
  } result_set_t;

endpackage

`default_nettype wire

// ===== design/sem_luma.sv =====
// Fixed-point BGR to 8-bit luma conversion.
`default_nettype none

module sem_luma (
  input  wire logic [sem_pkg::PIX_W-1:0] blue,
  input  wire logic [sem_pkg::PIX_W-1:0] green,
  input  wire logic [sem_pkg::PIX_W-1:0] red,
  output logic [sem_pkg::PIX_W-1:0] luma
);

  logic [23:0] weighted_sum;

  always_comb begin
    weighted_sum = 24'(sem_pkg::LUMA_WEIGHT_RED) * 24'(red)
                 + 24'(sem_pkg::LUMA_WEIGHT_GREEN) * 24'(green)
                 + 24'(sem_pkg::LUMA_WEIGHT_BLUE) * 24'(blue);
    luma = weighted_sum[23:16];
  end

endmodule

`default_nettype wire

// ===== design/sem_filter.sv =====
// Two luma line stores, the 3x3 window and the Sobel magnitude logic.
`default_nettype none

module sem_filter #(
  parameter int DEPTH = 2048
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic restart,
  input  wire logic rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [sem_pkg::PIX_W-1:0] luma,
  output logic [sem_pkg::PIX_W-1:0] edge_raw
);

  logic [sem_pkg::PIX_W-1:0] line_older [DEPTH];
  logic [sem_pkg::PIX_W-1:0] line_newer [DEPTH];
  logic [sem_pkg::PIX_W-1:0] top_right;
  logic [sem_pkg::PIX_W-1:0] mid_right;
  logic [sem_pkg::PIX_W-1:0] win [6];
  logic bypass;
  logic signed [11:0] tl, ml, bl, tm, bm, tr, mr, br;
  logic signed [11:0] gx, gy;
  logic [10:0] abs_gx, abs_gy;
  logic [11:0] magnitude;

  assign bypass = wr_en && (rd_addr == wr_addr);

  // A row of width one reads the entry that the pixel ahead of it writes in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_older[wr_addr] <= mid_right;
      line_newer[wr_addr] <= luma;
    end
    if (rd_en) begin
      if (bypass) begin
        top_right <= mid_right;
        mid_right <= luma;
      end else begin
        top_right <= line_older[rd_addr];
        mid_right <= line_newer[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (wr_en) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_right;
      win[4] <= mid_right;
      win[5] <= luma;
    end
  end

  always_comb begin
    tl = $signed({4'b0, win[0]});
    ml = $signed({4'b0, win[1]});
    bl = $signed({4'b0, win[2]});
    tm = $signed({4'b0, win[3]});
    bm = $signed({4'b0, win[5]});
    tr = $signed({4'b0, top_right});
    mr = $signed({4'b0, mid_right});
    br = $signed({4'b0, luma});
    gx = tr + br + (mr <<< 1) - tl - (ml <<< 1) - bl;
    gy = tl + tr + (tm <<< 1) - bl - br - (bm <<< 1);
    abs_gx = gx[11] ? 11'(-gx) : 11'(gx);
    abs_gy = gy[11] ? 11'(-gy) : 11'(gy);
    magnitude = 12'(abs_gx) + 12'(abs_gy);
    edge_raw = (magnitude > 12'(sem_pkg::EDGE_MAX)) ? sem_pkg::EDGE_MAX : magnitude[7:0];
  end

endmodule

`default_nettype wire

// ===== design/sem_drain.sv =====
// Result register that hands out the results of one pixel, one per cycle while result_stall is low.
`default_nettype none

module sem_drain (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire sem_pkg::result_set_t load_set,
  output logic free,
  output logic result_valid,
  input  wire logic result_stall,
  output logic [sem_pkg::PIX_W-1:0] edge_value,
  output logic [sem_pkg::ROW_W-1:0] out_row,
  output logic [sem_pkg::COL_OUT_W-1:0] out_col,
  output logic last
);

  sem_pkg::result_set_t set;
  sem_pkg::slot_t slot;
  logic [sem_pkg::SLOTS-1:0] slot_bit;
  logic [sem_pkg::SLOTS-1:0] remaining;
  logic fire;

  always_comb begin
    if (set.mask[sem_pkg::SLOT_UP_LEFT]) begin
      slot = sem_pkg::SLOT_UP_LEFT;
    end else if (set.mask[sem_pkg::SLOT_UP]) begin
      slot = sem_pkg::SLOT_UP;
    end else if (set.mask[sem_pkg::SLOT_LEFT]) begin
      slot = sem_pkg::SLOT_LEFT;
    end else begin
      slot = sem_pkg::SLOT_HERE;
    end
    slot_bit = sem_pkg::SLOTS'(1) << slot;
    remaining = set.mask & ~slot_bit;
    result_valid = |set.mask;
    last = (remaining == '0);
    fire = result_valid && !result_stall;
    free = !result_valid || (fire && last);
    edge_value = (slot == sem_pkg::SLOT_UP_LEFT) ? set.edge_value : '0;
    case (slot)
      sem_pkg::SLOT_UP_LEFT: begin
        out_row = set.row_prev;
        out_col = set.col_prev;
      end
      sem_pkg::SLOT_UP: begin
        out_row = set.row_prev;
        out_col = set.col_cur;
      end
      sem_pkg::SLOT_LEFT: begin
        out_row = set.row_cur;
        out_col = set.col_prev;
      end
      default: begin
        out_row = set.row_cur;
        out_col = set.col_cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set.mask <= '0;
    end else if (load) begin
      set.mask <= load_set.mask;
    end else if (fire) begin
      set.mask <= remaining;
    end
    if (load) begin
      set.edge_value <= load_set.edge_value;
      set.row_prev <= load_set.row_prev;
      set.row_cur <= load_set.row_cur;
      set.col_prev <= load_set.col_prev;
      set.col_cur <= load_set.col_cur;
    end
  end

endmodule

`default_nettype wire

// ===== design/sobel_edge_magnitude_core.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude core.
// Path: an accepted pixel is registered in s1, then moves into the result register once that is free.
// Throughput: one pixel per cycle while result_stall is low; a pixel with k results (k up to 4 at row
// ends of the last row) holds the input until the single result port has handed out its results.
// Reset: synchronous; width 640, height 480, position and window cleared.
// Line store contents are not cleared; no clearing pass is needed.
`default_nettype none

module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire sem_pkg::reg_index_t cfg_index,
  input  wire logic [sem_pkg::CFG_W-1:0] cfg_data,
  input  wire logic pixel_valid,
  output logic pixel_stall,
  input  wire logic [sem_pkg::PIX_W-1:0] blue,
  input  wire logic [sem_pkg::PIX_W-1:0] green,
  input  wire logic [sem_pkg::PIX_W-1:0] red,
  output logic result_valid,
  input  wire logic result_stall,
  output logic [sem_pkg::PIX_W-1:0] edge_value,
  output logic [sem_pkg::ROW_W-1:0] out_row,
  output logic [sem_pkg::COL_OUT_W-1:0] out_col,
  output logic last
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WBITS = (AW + 1 > sem_pkg::FW_W) ? AW + 1 : sem_pkg::FW_W;

  logic [sem_pkg::FW_W-1:0] frame_width;
  logic [sem_pkg::FH_W-1:0] frame_height;
  logic [sem_pkg::ROW_W-1:0] row_count;
  logic [AW-1:0] col_count;

  logic s1_valid;
  logic [sem_pkg::ROW_W-1:0] s1_row;
  logic [AW-1:0] s1_col;
  logic s1_row_end;
  logic s1_last_row;
  logic [sem_pkg::PIX_W-1:0] s1_luma;

  logic [WBITS-1:0] width_ext;
  logic [WBITS-1:0] col_last_full;
  logic [AW-1:0] col_last;
  logic [sem_pkg::ROW_W-1:0] row_last;
  logic row_end;
  logic last_row;
  logic accept;
  logic s1_fire;
  logic drain_free;
  logic [sem_pkg::PIX_W-1:0] pixel_luma;
  logic [sem_pkg::PIX_W-1:0] edge_raw;
  logic [31:0] col_cur_wide;
  logic [31:0] col_prev_wide;
  logic row_nonzero;
  logic col_nonzero;
  logic interior;
  sem_pkg::result_set_t load_set;

  always_comb begin
    width_ext = WBITS'(frame_width);
    if (frame_width == '0) begin
      col_last_full = '0;
    end else if (width_ext > WBITS'(MAX_WIDTH)) begin
      col_last_full = WBITS'(MAX_WIDTH) - WBITS'(1);
    end else begin
      col_last_full = width_ext - WBITS'(1);
    end
    col_last = col_last_full[AW-1:0];
    row_last = (frame_height == '0) ? '0 : frame_height - 16'd1;
    row_end = (col_count == col_last);
    last_row = (row_count == row_last);
  end

  assign pixel_stall = s1_valid && !drain_free;
  assign accept = pixel_valid && !pixel_stall;
  assign s1_fire = s1_valid && drain_free;

  // A register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= sem_pkg::FRAME_WIDTH_RESET;
      frame_height <= sem_pkg::FRAME_HEIGHT_RESET;
      row_count <= '0;
      col_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sem_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data[sem_pkg::FW_W-1:0];
          sem_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[sem_pkg::FH_W-1:0];
          default: frame_width <= frame_width;
        endcase
        row_count <= '0;
        col_count <= '0;
      end else if (accept) begin
        if (row_end) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + 16'd1;
        end else begin
          col_count <= col_count + AW'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= row_count;
      s1_col <= col_count;
      s1_row_end <= row_end;
      s1_last_row <= last_row;
      s1_luma <= pixel_luma;
    end
  end

  sem_luma u_luma (
    .blue(blue),
    .green(green),
    .red(red),
    .luma(pixel_luma)
  );

  sem_filter #(
    .DEPTH(MAX_WIDTH)
  ) u_filter (
    .clk(clk),
    .rst(rst),
    .restart(cfg_write),
    .rd_en(accept),
    .rd_addr(col_count),
    .wr_en(s1_fire),
    .wr_addr(s1_col),
    .luma(s1_luma),
    .edge_raw(edge_raw)
  );

  always_comb begin
    col_cur_wide = 32'(s1_col);
    col_prev_wide = 32'(s1_col) - 32'd1;
    row_nonzero = (s1_row != '0);
    col_nonzero = (s1_col != '0);
    interior = (s1_row >= 16'd2) && (32'(s1_col) >= 32'd2);
    load_set.mask[sem_pkg::SLOT_UP_LEFT] = row_nonzero && col_nonzero;
    load_set.mask[sem_pkg::SLOT_UP] = row_nonzero && s1_row_end;
    load_set.mask[sem_pkg::SLOT_LEFT] = s1_last_row && col_nonzero;
    load_set.mask[sem_pkg::SLOT_HERE] = s1_last_row && s1_row_end;
    load_set.edge_value = interior ? edge_raw : '0;
    load_set.row_prev = s1_row - 16'd1;
    load_set.row_cur = s1_row;
    load_set.col_prev = col_prev_wide[sem_pkg::COL_OUT_W-1:0];
    load_set.col_cur = col_cur_wide[sem_pkg::COL_OUT_W-1:0];
  end

  sem_drain u_drain (
    .clk(clk),
    .rst(rst),
    .load(s1_fire),
    .load_set(load_set),
    .free(drain_free),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .edge_value(edge_value),
    .out_row(out_row),
    .out_col(out_col),
    .last(last)
  );

endmodule

`default_nettype wire

// ===== sim/tb_sobel_edge_magnitude_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the streaming Sobel edge magnitude core with random stimulus.
module tb_sobel_edge_magnitude_core;

  localparam int MAX_WIDTH = 2048;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 114;
  localparam int WEIGHT_R = 19595;
  localparam int WEIGHT_G = 38470;
  localparam int WEIGHT_B = 7471;

  typedef struct {
    logic [sem_pkg::PIX_W-1:0] mag;
    logic [sem_pkg::ROW_W-1:0] row;
    logic [sem_pkg::COL_OUT_W-1:0] col;
    logic is_last;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  sem_pkg::reg_index_t cfg_index = sem_pkg::REG_FRAME_WIDTH;
  logic [sem_pkg::CFG_W-1:0] cfg_data = '0;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic [sem_pkg::PIX_W-1:0] blue = '0;
  logic [sem_pkg::PIX_W-1:0] green = '0;
  logic [sem_pkg::PIX_W-1:0] red = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [sem_pkg::PIX_W-1:0] edge_value;
  logic [sem_pkg::ROW_W-1:0] out_row;
  logic [sem_pkg::COL_OUT_W-1:0] out_col;
  logic last;

  logic rx_hold = 1'b0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_wait = 0;
  int idle_cycles = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int frames_started = 0;
  int error_count = 0;

  logic [sem_pkg::FW_W-1:0] model_width = sem_pkg::FRAME_WIDTH_RESET;
  logic [sem_pkg::FH_W-1:0] model_height = sem_pkg::FRAME_HEIGHT_RESET;
  logic [7:0] older_line [MAX_WIDTH];
  logic [7:0] newer_line [MAX_WIDTH];
  logic [7:0] window [6];
  int pos_row = 0;
  int pos_col = 0;
  edge_result_t pending_edges[$];

  sobel_edge_magnitude_core #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .blue(blue),
    .green(green),
    .red(red),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .edge_value(edge_value),
    .out_row(out_row),
    .out_col(out_col),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void restart_frame();
    pos_row = 0;
    pos_col = 0;
    foreach (window[i]) window[i] = '0;
  endfunction

  function automatic edge_result_t make_result(input int mag, input int row, input int col);
    edge_result_t res;
    res.mag = sem_pkg::PIX_W'(mag);
    res.row = sem_pkg::ROW_W'(row);
    res.col = sem_pkg::COL_OUT_W'(col);
    res.is_last = 1'b0;
    return res;
  endfunction

  function automatic void predict_edges(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r);
    int w, h, y, tl, ml, bl, tm, bm, tr, mr, br, gx, gy, mag;
    bit row_end, last_row;
    edge_result_t found[$];
    w = (model_width == 0) ? 1 : ((model_width > MAX_WIDTH) ? MAX_WIDTH : model_width);
    h = (model_height == 0) ? 1 : model_height;
    y = (WEIGHT_R * int'(r) + WEIGHT_G * int'(g) + WEIGHT_B * int'(b)) >> 16;
    row_end = (pos_col + 1 >= w);
    last_row = (pos_row + 1 >= h);
    tl = window[0];
    ml = window[1];
    bl = window[2];
    tm = window[3];
    bm = window[5];
    tr = older_line[pos_col];
    mr = newer_line[pos_col];
    br = y;
    gx = tr - tl + 2 * (mr - ml) + br - bl;
    gy = tl + 2 * tm + tr - bl - 2 * bm - br;
    mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
    if (pos_row < 2 || pos_col < 2) begin
      mag = 0;
    end else if (mag > int'(sem_pkg::EDGE_MAX)) begin
      mag = int'(sem_pkg::EDGE_MAX);
    end
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = 8'(tr);
    window[4] = 8'(mr);
    window[5] = 8'(y);
    older_line[pos_col] = 8'(mr);
    newer_line[pos_col] = 8'(y);
    if (pos_row >= 1 && pos_col >= 1) begin
      found.insert(found.size(), make_result(mag, pos_row - 1, pos_col - 1));
    end
    if (pos_row >= 1 && row_end) begin
      found.insert(found.size(), make_result(0, pos_row - 1, pos_col));
    end
    if (last_row && pos_col >= 1) begin
      found.insert(found.size(), make_result(0, pos_row, pos_col - 1));
    end
    if (last_row && row_end) begin
      found.insert(found.size(), make_result(0, pos_row, pos_col));
    end
    if (found.size() > 0) found[found.size() - 1].is_last = 1'b1;
    foreach (found[i]) pending_edges.insert(pending_edges.size(), found[i]);
    if (row_end) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endfunction

  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    blue <= b;
    green <= g;
    red <= r;
    do @(posedge clk); while (pixel_stall !== 1'b0);
    predict_edges(b, g, r);
    pixels_sent++;
  endtask

  task automatic send_random_frame(input int count);
    repeat (count) send_pixel(random_channel(), random_channel(), random_channel());
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input sem_pkg::reg_index_t idx,
                                input logic [sem_pkg::CFG_W-1:0] value);
    logic [sem_pkg::CFG_W-1:0] data;
    data = value;
    if (idx == sem_pkg::REG_FRAME_WIDTH) begin
      data[sem_pkg::CFG_W-1:sem_pkg::FW_W] = (sem_pkg::CFG_W - sem_pkg::FW_W)'($urandom);
    end
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == sem_pkg::REG_FRAME_WIDTH) begin
      model_width = data[sem_pkg::FW_W-1:0];
    end else begin
      model_height = data[sem_pkg::FH_W-1:0];
    end
    restart_frame();
  endtask

  task automatic set_frame(input int w, input int h);
    write_register(sem_pkg::REG_FRAME_WIDTH, sem_pkg::CFG_W'(w));
    write_register(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::CFG_W'(h));
    frames_started++;
  endtask

  task automatic test_reset_defaults();
    send_random_frame(2);
  endtask

  task automatic test_saturated_edges();
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i % 3 == 2) begin
        send_pixel(8'hFF, 8'hFF, 8'hFF);
      end else begin
        send_pixel(8'h00, 8'h00, 8'h00);
      end
    end
  endtask

  task automatic test_degenerate_sizes();
    set_frame(0, 0);
    send_random_frame(1);
    set_frame(1, 2);
    send_random_frame(2);
  endtask

  task automatic test_large_registers();
    set_frame(4095, 1);
    send_random_frame(3);
    set_frame(2048, 1);
    send_random_frame(3);
    set_frame(3, 65535);
    send_random_frame(6);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_frame(5, 6);
    // The result side refuses every request for a long stretch so the core backs up.
    fork
      begin
        rx_hold <= 1'b1;
        repeat (60) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_random_frame(30);
    drain_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_frames();
    int w, h, count, mode, first_item;
    first_item = pixels_sent;
    while (pixels_sent < first_item + RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if (mode == 9) begin
        w = $urandom_range(9, 24);
        h = $urandom_range(1, 2);
      end else if (mode == 6) begin
        w = $urandom_range(0, 3);
        h = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
      end
      set_frame(w, h);
      count = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      if (mode == 8) begin
        count = $urandom_range(1, count);
      end else if (mode == 7) begin
        count = 2 * count;
      end
      if (count > first_item + RANDOM_ITEMS - pixels_sent) begin
        count = first_item + RANDOM_ITEMS - pixels_sent;
      end
      send_random_frame(count);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  always @(posedge clk) begin : check_results
    edge_result_t want;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (pending_edges.size() == 0) begin
        $error("result at row %0d col %0d with no expectation waiting", out_row, out_col);
        error_count++;
      end else begin
        want = pending_edges.pop_front();
        compare_field("edge_value", want.mag, edge_value);
        compare_field("out_row", want.row, out_row);
        compare_field("out_col", want.col, out_col);
        compare_field("last", want.is_last, last);
        results_checked++;
      end
      rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    result_stall <= (rx_wait != 0) || rx_hold;
  end

  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sobel_edge_magnitude_core regression: fail");
      $finish;
    end
  end

  initial begin
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    restart_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_saturated_edges();
    test_degenerate_sizes();
    test_large_registers();
    test_backpressure();
    test_random_frames();
    drain_results();
    $display("Sent %0d pixel requests over %0d frame setups and checked %0d results.",
             pixels_sent, frames_started, results_checked);
    $display("Covered saturation, zero and oversized dimensions, frame wrap and back-pressure.");
    if (error_count == 0) begin
      $display("sobel_edge_magnitude_core regression: pass");
    end else begin
      $display("sobel_edge_magnitude_core regression: fail");
    end
    $finish;
  end

endmodule
